// ===== hw/rtl/utf_to_utf8_sanitizing_transcoder_top_macros.svh =====
// Assertion helpers shared by the transcoder RTL.
`ifndef UTF_TO_UTF8_SANITIZING_TRANSCODER_TOP_MACROS_SVH
`define UTF_TO_UTF8_SANITIZING_TRANSCODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// ante |-> cons, checked outside reset
`define UTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("utf8tc: implication check failed");
// cond must never be true outside reset
`define UTC_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("utf8tc: forbidden condition seen");
`else
`define UTC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UTC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hw/rtl/utf8tc_pkg.sv =====
package utf8tc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CP_W            = 21;

    typedef logic [CP_W-1:0] cp_t;

    localparam cp_t REPL_CP = 21'h00FFFD;

    typedef enum logic [1:0] {
        ENC_UTF8  = 2'd0,
        ENC_UTF16 = 2'd1,
        ENC_UTF32 = 2'd2,
        ENC_NONE  = 2'd3
    } enc_t;

    // front sequencer
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_U8,
        FS_LIST,
        FS_FIN
    } fstate_t;

    // one code point handed from front to back
    typedef struct packed {
        cp_t  cp;
        logic last;
    } qent_t;

    // push side of the queue
    typedef struct packed {
        logic  push;
        qent_t ent;
    } qpush_t;

    // UTF-8 bytes, first byte in the low bits
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } utf8_seq_t;

    // surrogates and values above U+10FFFF become U+FFFD
    function automatic utf8_seq_t utf8_encode(cp_t cp_in);
        cp_t       cp;
        utf8_seq_t s;
        cp = cp_in;
        if ((cp > 21'h10FFFF) || (cp inside {[21'h00D800:21'h00DFFF]}))
        begin
            cp = REPL_CP;
        end
        s.bytes = '0;
        if (cp <= 21'h00007F)
        begin
            s.bytes[7:0] = {1'b0, cp[6:0]};
            s.len        = 3'd1;
        end
        else if (cp <= 21'h0007FF)
        begin
            s.bytes[7:0]  = {3'b110, cp[10:6]};
            s.bytes[15:8] = {2'b10, cp[5:0]};
            s.len         = 3'd2;
        end
        else if (cp <= 21'h00FFFF)
        begin
            s.bytes[7:0]   = {4'b1110, cp[15:12]};
            s.bytes[15:8]  = {2'b10, cp[11:6]};
            s.bytes[23:16] = {2'b10, cp[5:0]};
            s.len          = 3'd3;
        end
        else
        begin
            s.bytes[7:0]   = {5'b11110, cp[20:18]};
            s.bytes[15:8]  = {2'b10, cp[17:12]};
            s.bytes[23:16] = {2'b10, cp[11:6]};
            s.bytes[31:24] = {2'b10, cp[5:0]};
            s.len          = 3'd4;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/utf8tc_queue.sv =====
`include "utf_to_utf8_sanitizing_transcoder_top_macros.svh"

module utf8tc_queue
    import utf8tc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  qpush_t wr,
    output logic   full,
    input  logic   pop,
    output qent_t  rdata,
    output logic   empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qent_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (wr.push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !wr.push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.ent;
        end
    end

    `UTC_ASSERT_NEVER(a_q_push_full, clk, rst_n, wr.push && full)
    `UTC_ASSERT_NEVER(a_q_pop_empty, clk, rst_n, pop && empty)

endmodule

// ===== hw/rtl/utf8tc_front.sv =====
`include "utf_to_utf8_sanitizing_transcoder_top_macros.svh"

module utf8tc_front
    import utf8tc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output qpush_t     q_wr,
    input  logic       q_full
);

    fstate_t      state_reg, state_next;
    enc_t         enc_reg, enc_next;
    logic [7:0]   pb_reg [3];
    logic [7:0]   pb_next [3];
    logic [1:0]   pcnt_reg, pcnt_next;
    logic         hold_reg, hold_next;
    logic [31:0]  win_reg, win_next;
    logic [2:0]   wcnt_reg, wcnt_next;
    logic         eod_reg, eod_next;
    cp_t          lst_cp_reg [3];
    cp_t          lst_cp_next [3];
    logic [2:0]   lst_v_reg, lst_v_next;
    cp_t          held_cp_reg, held_cp_next;
    logic         held_v_reg, held_v_next;

    logic         acc;
    // UTF-8 decode step
    logic         u8_gen, u8_clear, u8_stop, u8_fin, lead_ok, cont_ok, overlong;
    cp_t          u8_cp, dec_cp;
    logic [2:0]   u8_drop, u8_len, u8_cnt_next;
    logic [7:0]   lead, b1, b2, b3;
    // list walk
    logic [2:0]   lst_sel;
    cp_t          lst_sel_cp;
    logic         gen, advance;
    cp_t          gen_cp;

    assign s_tready = (state_reg == FS_IDLE);
    assign acc      = s_tvalid && s_tready;

    assign lead = win_reg[7:0];
    assign b1   = win_reg[15:8];
    assign b2   = win_reg[23:16];
    assign b3   = win_reg[31:24];

    // one decode attempt at the head of the window
    always_comb
    begin
        u8_gen   = 1'b0;
        u8_cp    = REPL_CP;
        u8_drop  = 3'd0;
        u8_clear = 1'b0;
        u8_stop  = 1'b0;
        u8_len   = 3'd1;
        lead_ok  = 1'b1;
        cont_ok  = 1'b1;
        overlong = 1'b0;
        dec_cp   = {13'b0, lead};
        case (lead) inside
            [8'h00:8'h7F]:
            begin
                u8_len = 3'd1;
            end
            [8'hC0:8'hDF]:
            begin
                u8_len   = 3'd2;
                dec_cp   = {10'b0, lead[4:0], b1[5:0]};
                cont_ok  = (b1[7:6] == 2'b10);
                overlong = (dec_cp < 21'h000080);
            end
            [8'hE0:8'hEF]:
            begin
                u8_len   = 3'd3;
                dec_cp   = {5'b0, lead[3:0], b1[5:0], b2[5:0]};
                cont_ok  = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
                overlong = (dec_cp < 21'h000800);
            end
            [8'hF0:8'hF7]:
            begin
                u8_len   = 3'd4;
                dec_cp   = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
                cont_ok  = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) &&
                           (b3[7:6] == 2'b10);
                overlong = (dec_cp < 21'h010000);
            end
            default:
            begin
                lead_ok = 1'b0;
            end
        endcase

        if (wcnt_reg == 3'd0)
        begin
            u8_stop = 1'b1;
        end
        else if (!lead_ok)
        begin
            u8_gen  = 1'b1;
            u8_drop = 3'd1;
        end
        else if (wcnt_reg < u8_len)
        begin
            // sequence not complete yet; at end of data it is one U+FFFD
            u8_stop  = 1'b1;
            u8_gen   = eod_reg;
            u8_clear = eod_reg;
        end
        else if (!cont_ok || overlong)
        begin
            // only the lead goes, the rest is decoded again
            u8_gen  = 1'b1;
            u8_drop = 3'd1;
        end
        else
        begin
            u8_gen  = 1'b1;
            u8_cp   = dec_cp;
            u8_drop = u8_len;
        end
        u8_cnt_next = u8_clear ? 3'd0 : (wcnt_reg - u8_drop);
        u8_fin      = u8_stop || (u8_cnt_next == 3'd0);
    end

    // lowest pending list entry first
    always_comb
    begin
        lst_sel = lst_v_reg & (~lst_v_reg + 3'd1);
        if (lst_v_reg[0])
        begin
            lst_sel_cp = lst_cp_reg[0];
        end
        else if (lst_v_reg[1])
        begin
            lst_sel_cp = lst_cp_reg[1];
        end
        else
        begin
            lst_sel_cp = lst_cp_reg[2];
        end
    end

    // a new code point can only displace the held one if the queue has room
    always_comb
    begin
        gen     = 1'b0;
        gen_cp  = lst_sel_cp;
        advance = 1'b1;
        case (state_reg)
            FS_U8:
            begin
                gen     = u8_gen;
                gen_cp  = u8_cp;
                advance = !(u8_gen && held_v_reg && q_full);
            end
            FS_LIST:
            begin
                gen     = |lst_v_reg;
                advance = !((|lst_v_reg) && held_v_reg && q_full);
            end
            FS_FIN:
            begin
                advance = !(held_v_reg && q_full);
            end
            default:
            begin
                advance = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (acc)
                begin
                    state_next = (enc_reg == ENC_UTF8) ? FS_U8 : FS_LIST;
                end
            end
            FS_U8:
            begin
                if (advance && u8_fin)
                begin
                    state_next = FS_FIN;
                end
            end
            FS_LIST:
            begin
                if (advance && ((lst_v_reg & ~lst_sel) == 3'd0))
                begin
                    state_next = FS_FIN;
                end
            end
            FS_FIN:
            begin
                if (advance)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic [15:0] unit;
        logic        is_lo, is_hi, consumed, hold_new;
        logic [31:0] cp32;

        enc_next     = enc_reg;
        pb_next      = pb_reg;
        pcnt_next    = pcnt_reg;
        hold_next    = hold_reg;
        win_next     = win_reg;
        wcnt_next    = wcnt_reg;
        eod_next     = eod_reg;
        lst_cp_next  = lst_cp_reg;
        lst_v_next   = lst_v_reg;
        held_cp_next = held_cp_reg;
        held_v_next  = held_v_reg;
        q_wr.push    = 1'b0;
        q_wr.ent     = '{cp: held_cp_reg, last: 1'b0};

        unit     = {s_tdata, pb_reg[0]};
        is_lo    = unit inside {[16'hDC00:16'hDFFF]};
        is_hi    = unit inside {[16'hD800:16'hDBFF]};
        consumed = hold_reg && is_lo;
        hold_new = !consumed && is_hi;
        cp32     = {s_tdata, pb_reg[2], pb_reg[1], pb_reg[0]};

        case (state_reg)
            FS_IDLE:
            begin
                if (acc)
                begin
                    lst_v_next = 3'b000;
                    case (enc_reg)
                        ENC_UTF8:
                        begin
                            win_next = {8'h00, pb_reg[2], pb_reg[1], pb_reg[0]};
                            case (pcnt_reg)
                                2'd0:    win_next[7:0]   = s_tdata;
                                2'd1:    win_next[15:8]  = s_tdata;
                                2'd2:    win_next[23:16] = s_tdata;
                                default: win_next[31:24] = s_tdata;
                            endcase
                            wcnt_next = {1'b0, pcnt_reg} + 3'd1;
                            eod_next  = s_tlast;
                        end
                        ENC_UTF16:
                        begin
                            lst_cp_next[0] = consumed ?
                                (21'h010000
                                 + {1'b0, pb_reg[2][1:0], pb_reg[1], unit[9:0]}) :
                                REPL_CP;
                            lst_cp_next[1] = {5'b0, unit};
                            lst_cp_next[2] = REPL_CP;
                            if (pcnt_reg == 2'd0)
                            begin
                                pb_next[0] = s_tdata;
                                pcnt_next  = 2'd1;
                                lst_v_next = {s_tlast && hold_reg, 2'b00};
                            end
                            else
                            begin
                                pb_next[0] = 8'h00;
                                pcnt_next  = 2'd0;
                                hold_next  = hold_new;
                                if (hold_new)
                                begin
                                    pb_next[1] = unit[7:0];
                                    pb_next[2] = unit[15:8];
                                end
                                lst_v_next = {s_tlast && hold_new,
                                              !consumed && !is_hi,
                                              hold_reg};
                            end
                        end
                        ENC_UTF32:
                        begin
                            if (pcnt_reg != 2'd3)
                            begin
                                pb_next[pcnt_reg] = s_tdata;
                                pcnt_next         = pcnt_reg + 2'd1;
                            end
                            else
                            begin
                                pcnt_next      = 2'd0;
                                lst_cp_next[0] = (cp32[31:21] != 11'd0) ? REPL_CP :
                                                 cp32[20:0];
                                lst_v_next     = 3'b001;
                            end
                        end
                        default:
                        begin
                            lst_v_next = 3'b000;
                        end
                    endcase
                    if (s_tlast && (enc_reg != ENC_UTF8))
                    begin
                        pcnt_next = 2'd0;
                        hold_next = 1'b0;
                    end
                end
            end
            FS_U8:
            begin
                if (advance)
                begin
                    win_next  = win_reg >> {u8_drop, 3'b000};
                    wcnt_next = u8_cnt_next;
                    if (u8_fin)
                    begin
                        // leftover bytes stay buffered for the next word
                        pb_next[0] = win_next[7:0];
                        pb_next[1] = win_next[15:8];
                        pb_next[2] = win_next[23:16];
                        pcnt_next  = eod_reg ? 2'd0 : wcnt_next[1:0];
                        hold_next  = 1'b0;
                    end
                end
            end
            FS_LIST:
            begin
                if (advance)
                begin
                    lst_v_next = lst_v_reg & ~lst_sel;
                end
            end
            FS_FIN:
            begin
                if (advance)
                begin
                    q_wr.push     = held_v_reg;
                    q_wr.ent.last = 1'b1;
                    held_v_next   = 1'b0;
                end
            end
            default:
            begin
                held_v_next = 1'b0;
            end
        endcase

        // the held code point goes out once it is known not to be the last
        if (((state_reg == FS_U8) || (state_reg == FS_LIST)) && advance && gen)
        begin
            q_wr.push    = held_v_reg;
            held_cp_next = gen_cp;
            held_v_next  = 1'b1;
        end

        if (cfg_we)
        begin
            enc_next   = enc_t'(cfg_wdata);
            pb_next[0] = 8'h00;
            pb_next[1] = 8'h00;
            pb_next[2] = 8'h00;
            pcnt_next  = 2'd0;
            hold_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FS_IDLE;
            enc_reg    <= ENC_UTF8;
            pb_reg[0]  <= 8'h00;
            pb_reg[1]  <= 8'h00;
            pb_reg[2]  <= 8'h00;
            pcnt_reg   <= 2'd0;
            hold_reg   <= 1'b0;
            wcnt_reg   <= 3'd0;
            eod_reg    <= 1'b0;
            lst_v_reg  <= 3'b000;
            held_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            enc_reg    <= enc_next;
            pb_reg     <= pb_next;
            pcnt_reg   <= pcnt_next;
            hold_reg   <= hold_next;
            wcnt_reg   <= wcnt_next;
            eod_reg    <= eod_next;
            lst_v_reg  <= lst_v_next;
            held_v_reg <= held_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg     <= win_next;
        lst_cp_reg  <= lst_cp_next;
        held_cp_reg <= held_cp_next;
    end

    `UTC_ASSERT_IMP(a_idle_nothing_held, clk, rst_n, state_reg == FS_IDLE, !held_v_reg)
    `UTC_ASSERT_IMP(a_u8_window_nonempty, clk, rst_n, state_reg == FS_U8, wcnt_reg != 3'd0)

endmodule

// ===== hw/rtl/utf8tc_back.sv =====
`include "utf_to_utf8_sanitizing_transcoder_top_macros.svh"

module utf8tc_back
    import utf8tc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    output logic       q_pop,
    input  qent_t      q_rdata,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic        enc_v_reg, enc_v_next;
    logic [31:0] seq_reg, seq_next;
    logic [2:0]  len_reg, len_next;
    logic [1:0]  pos_reg, pos_next;
    logic        last_reg, last_next;
    logic        out_v_reg, out_v_next;
    logic [7:0]  out_b_reg, out_b_next;
    logic        out_l_reg, out_l_next;

    logic        out_take, emit, last_byte;
    logic [31:0] seq_shift;
    utf8_seq_t   enc;

    assign out_take  = !out_v_reg || m_tready;
    assign emit      = enc_v_reg && out_take;
    assign last_byte = (({1'b0, pos_reg} + 3'd1) == len_reg);
    assign seq_shift = seq_reg >> {pos_reg, 3'b000};
    assign q_pop     = !q_empty && (!enc_v_reg || (emit && last_byte));
    assign enc       = utf8_encode(q_rdata.cp);

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_b_reg;
    assign m_tlast  = out_l_reg;

    always_comb
    begin
        enc_v_next = enc_v_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        out_v_next = out_v_reg;
        out_b_next = out_b_reg;
        out_l_next = out_l_reg;

        if (out_take)
        begin
            out_v_next = emit;
            if (emit)
            begin
                out_b_next = seq_shift[7:0];
                out_l_next = last_reg && last_byte;
            end
        end

        if (q_pop)
        begin
            enc_v_next = 1'b1;
            seq_next   = enc.bytes;
            len_next   = enc.len;
            pos_next   = 2'd0;
            last_next  = q_rdata.last;
        end
        else if (emit && last_byte)
        begin
            enc_v_next = 1'b0;
        end
        else if (emit)
        begin
            pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            enc_v_reg <= enc_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg   <= seq_next;
        len_reg   <= len_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
        out_b_reg <= out_b_next;
        out_l_reg <= out_l_next;
    end

    `UTC_ASSERT_IMP(a_pos_in_range, clk, rst_n, enc_v_reg, {1'b0, pos_reg} < len_reg)

endmodule

// ===== hw/rtl/utf_to_utf8_sanitizing_transcoder_top.sv =====
// Sanitizing transcoder to UTF-8. Takes one source byte per word on the s_axis
// side in the encoding set by cfg_wdata (0 UTF-8, 1 UTF-16LE, 2 UTF-32LE, 3 drops
// all input) and returns well-formed UTF-8 bytes on m_axis, tlast marking the
// last output byte caused by each input word; an input word may cause no output.
// Bad leads, bad continuations, overlong forms, surrogates and values above
// U+10FFFF come out as U+FFFD. In UTF-8 a failed sequence costs only its lead
// byte and the following bytes are decoded again; s_axis_tlast flushes a
// truncated sequence or a lone high surrogate as one U+FFFD and clears the
// decoder, and a partial trailing UTF-16/32 unit is dropped. Writing the
// encoding register also clears the decoder; write it only while the block is
// idle. The front accepts each word in its idle state, then takes one decode
// step per code point found or per stall (UTF-8) or per queued code point
// (UTF-16/32, at least one), then a closing step, before it accepts the next
// word. The back end encodes and sends one output byte per cycle unless
// m_axis_tready holds it off; the code point queue lets a long UTF-8 sequence
// or a stalled output drain while the front decodes on until the queue fills.

module utf_to_utf8_sanitizing_transcoder_top
    import utf8tc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF    // code points in flight, >= 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    // encoding register
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,          // source_encoding
    // source bytes
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,       // [7:0] in_byte
    input  logic       s_axis_tlast,       // end_of_data
    // UTF-8 bytes
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,       // [7:0] out_byte
    output logic       m_axis_tlast        // run_last
);

    qpush_t q_wr;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    qent_t  q_rdata;

    // front: buffers partial sequences, decodes to code points
    utf8tc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tlast   (s_axis_tlast),
        .q_wr      (q_wr),
        .q_full    (q_full)
    );

    // code point queue, each entry tagged with the end-of-word flag
    utf8tc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // back: sanitizes, encodes and serializes bytes into the output register
    utf8tc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_rdata  (q_rdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/utf8_transcode_checker.sv =====
module utf8_transcode_checker
    import utf8tc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    output int         fail_count,
    output int         words_owed
);

    localparam logic [31:0] REPLACEMENT  = 32'h0000_FFFD;
    localparam int          MAX_WORD_OUT = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_word_t;

    // decoder copy
    enc_t       src_enc;
    logic [7:0] held [3];
    int         held_cnt;
    logic       hi_waiting;

    // UTF-8 work window, up to three held bytes plus the new one
    logic [7:0] seq_buf [4];
    int         seq_cnt;

    logic [7:0] word_out [$];
    utf8_word_t utf8_expected [$];
    utf8_word_t want;
    int         fails;

    function automatic void clear_decoder();
        int i;
        for (i = 0; i < 3; i++)
        begin
            held[i] = 8'h00;
        end
        held_cnt   = 0;
        hi_waiting = 1'b0;
    endfunction

    function automatic void put_out(logic [7:0] b);
        if (word_out.size() < MAX_WORD_OUT)
        begin
            word_out.insert(word_out.size(), b);
        end
    endfunction

    function automatic void emit_code_point(logic [31:0] cp_in);
        logic [31:0] cp;
        cp = cp_in;
        if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF))
        begin
            cp = REPLACEMENT;
        end
        if (cp <= 32'h7F)
        begin
            put_out(cp[7:0]);
        end
        else if (cp <= 32'h7FF)
        begin
            put_out({3'b110, cp[10:6]});
            put_out({2'b10, cp[5:0]});
        end
        else if (cp <= 32'hFFFF)
        begin
            put_out({4'b1110, cp[15:12]});
            put_out({2'b10, cp[11:6]});
            put_out({2'b10, cp[5:0]});
        end
        else
        begin
            put_out({5'b11110, cp[20:18]});
            put_out({2'b10, cp[17:12]});
            put_out({2'b10, cp[11:6]});
            put_out({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void drop_lead(int k);
        int i;
        for (i = 0; i + k < seq_cnt; i++)
        begin
            seq_buf[i] = seq_buf[i + k];
        end
        seq_cnt -= k;
    endfunction

    function automatic void scan_utf8(logic [7:0] b, logic eod);
        logic [7:0]  lead;
        logic [31:0] cp;
        int          len;
        int          i;
        logic        ok;
        for (i = 0; i < 3; i++)
        begin
            seq_buf[i] = held[i];
        end
        seq_buf[3]       = 8'h00;
        seq_cnt          = held_cnt;
        seq_buf[seq_cnt] = b;
        seq_cnt++;
        while (seq_cnt > 0)
        begin
            lead = seq_buf[0];
            ok   = 1'b1;
            if (lead < 8'h80)
            begin
                cp  = 32'(lead);
                len = 1;
            end
            else if ((lead & 8'hE0) == 8'hC0)
            begin
                cp  = 32'(lead & 8'h1F);
                len = 2;
            end
            else if ((lead & 8'hF0) == 8'hE0)
            begin
                cp  = 32'(lead & 8'h0F);
                len = 3;
            end
            else if ((lead & 8'hF8) == 8'hF0)
            begin
                cp  = 32'(lead & 8'h07);
                len = 4;
            end
            else
            begin
                emit_code_point(REPLACEMENT);
                drop_lead(1);
                continue;
            end
            // not enough bytes yet: wait, or flush one U+FFFD at end of data
            if (seq_cnt < len)
            begin
                if (eod)
                begin
                    emit_code_point(REPLACEMENT);
                    seq_cnt = 0;
                end
                break;
            end
            for (i = 1; i < len; i++)
            begin
                if ((seq_buf[i] & 8'hC0) != 8'h80)
                begin
                    ok = 1'b0;
                    break;
                end
                cp = (cp << 6) | 32'(seq_buf[i] & 8'h3F);
            end
            if (!ok || (len == 2 && cp < 32'h80) || (len == 3 && cp < 32'h800) ||
                (len == 4 && cp < 32'h10000))
            begin
                // bad sequence costs only its lead byte
                emit_code_point(REPLACEMENT);
                drop_lead(1);
                continue;
            end
            emit_code_point(cp);
            drop_lead(len);
        end
        for (i = 0; i < 3; i++)
        begin
            held[i] = (i < seq_cnt) ? seq_buf[i] : 8'h00;
        end
        held_cnt = seq_cnt;
    endfunction

    // held[0]: low byte of a half unit, held[1..2]: waiting high surrogate
    function automatic void decode_utf16(logic [7:0] b, logic eod);
        logic [31:0] unit;
        logic [31:0] hi;
        if (held_cnt == 0)
        begin
            held[0]  = b;
            held_cnt = 1;
        end
        else
        begin
            unit     = {16'h0000, b, held[0]};
            held_cnt = 0;
            held[0]  = 8'h00;
            if (hi_waiting)
            begin
                hi         = {16'h0000, held[2], held[1]};
                hi_waiting = 1'b0;
                if (unit >= 32'hDC00 && unit <= 32'hDFFF)
                begin
                    emit_code_point(32'h10000 + (((hi - 32'hD800) & 32'h3FF) << 10) +
                                    (unit - 32'hDC00));
                    unit = 32'h110000;    // used up by the pair
                end
                else
                begin
                    emit_code_point(REPLACEMENT);
                end
            end
            if (unit >= 32'hD800 && unit <= 32'hDBFF)
            begin
                held[1]    = unit[7:0];
                held[2]    = unit[15:8];
                hi_waiting = 1'b1;
            end
            else if (unit <= 32'hFFFF)
            begin
                emit_code_point(unit);
            end
        end
        if (eod && hi_waiting)
        begin
            emit_code_point(REPLACEMENT);
        end
    endfunction

    function automatic void decode_utf32(logic [7:0] b);
        if (held_cnt < 3)
        begin
            held[held_cnt] = b;
            held_cnt++;
        end
        else
        begin
            emit_code_point({b, held[2], held[1], held[0]});
            held[0]  = 8'h00;
            held[1]  = 8'h00;
            held[2]  = 8'h00;
            held_cnt = 0;
        end
    endfunction

    function automatic void predict_word(logic [7:0] b, logic eod);
        int         i;
        utf8_word_t w;
        word_out.delete();
        case (src_enc)
            ENC_UTF8:  scan_utf8(b, eod);
            ENC_UTF16: decode_utf16(b, eod);
            ENC_UTF32: decode_utf32(b);
            ENC_NONE:  ;
        endcase
        if (eod)
        begin
            clear_decoder();
        end
        for (i = 0; i < word_out.size(); i++)
        begin
            w.data = word_out[i];
            w.last = (i == word_out.size() - 1);
            utf8_expected.insert(utf8_expected.size(), w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_enc = ENC_UTF8;
            clear_decoder();
            utf8_expected.delete();
            fails = 0;
            fail_count <= 0;
            words_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                src_enc = enc_t'(cfg_wdata);
                clear_decoder();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_word(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (utf8_expected.size() == 0)
                begin
                    $error("out_byte: expected nothing, got %02h", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = utf8_expected.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
                        fails++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
                        fails++;
                    end
                end
            end
            fail_count <= fails;
            words_owed <= utf8_expected.size();
        end
    end

endmodule

// ===== test/utf_to_utf8_sanitizing_transcoder_top_test.sv =====
// Stimulus and verdict for the transcoder. All checking lives in the
// checker instance; this module only drives the ports and decides pass/fail.
module utf_to_utf8_sanitizing_transcoder_top_test;
    import utf8tc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 36;
    // covers the front's accept, decode and closing steps; padded for the queue
    localparam int SETTLE_CYCLES = 16;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_we        = 1'b0;
    logic [1:0] cfg_wdata     = ENC_UTF8;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;    // end_of_data
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;            // run_last

    // calm: no idling on either side, for one long stretch
    logic       calm          = 1'b0;
    int         cycles        = 0;
    int         fail_count;
    int         words_owed;
    logic [7:0] src_bytes [$];

    utf_to_utf8_sanitizing_transcoder_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_transcode_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .words_owed    (words_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: random back-pressure, none while calm
    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One word on s_axis. Random gaps first (valid low), then hold valid
    // until the edge where tready is seen high. Valid stays high between
    // back-to-back words, so it never gets two writes in one step.
    task automatic send_word(input logic [7:0] b, input logic eod);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // src_bytes as one buffer; end_of_data optionally on its last byte
    task automatic send_buffer(input logic eod_at_end);
        int i;
        for (i = 0; i < src_bytes.size(); i++)
        begin
            send_word(src_bytes[i], eod_at_end && (i == src_bytes.size() - 1));
        end
    endtask

    // Stop sending, wait for every predicted byte, then let words that
    // make no output (half units, ignored bytes) clear the front.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called while quiet
    task automatic set_encoding(input enc_t e);
        cfg_we    <= 1'b1;
        cfg_wdata <= e;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Code point mix: mostly valid across all UTF-8 lengths, some
    // surrogates, some out of range, plus a few boundary values.
    // wide: out-of-range values span 32 bits (UTF-32) instead of 21.
    function automatic logic [31:0] pick_code_point(input logic wide);
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            case ($urandom_range(8))
                0:       return 32'h0;
                1:       return 32'h7F;
                2:       return 32'h80;
                3:       return 32'h7FF;
                4:       return 32'h800;
                5:       return 32'hFFFF;
                6:       return 32'h10000;
                7:       return 32'h10FFFF;
                default: return 32'h110000;
            endcase
        end
        if (r < 35)
        begin
            return $urandom_range(32'h7F);
        end
        if (r < 55)
        begin
            return $urandom_range(32'h7FF, 32'h80);
        end
        if (r < 75)
        begin
            return $urandom_range(32'hFFFF, 32'h800);
        end
        if (r < 87)
        begin
            return $urandom_range(32'h10FFFF, 32'h10000);
        end
        if (r < 93)
        begin
            return $urandom_range(32'hDFFF, 32'hD800);
        end
        return wide ? $urandom() : $urandom_range(32'h1FFFFF, 32'h110000);
    endfunction

    // Raw UTF-8 encoding with no sanitizing, so surrogates and values
    // above U+10FFFF go out as is. Some sequences get an overlong form,
    // some are cut short, some get a broken continuation byte.
    task automatic add_utf8_symbol();
        logic [31:0] cp;
        logic [7:0]  seq [4];
        int          len;
        int          r;
        int          i;
        cp  = pick_code_point(1'b0);
        len = (cp <= 32'h7F) ? 1 : (cp <= 32'h7FF) ? 2 : (cp <= 32'hFFFF) ? 3 : 4;
        r   = $urandom_range(99);
        if (r < 8 && len < 4)
        begin
            len++;
        end
        case (len)
            1:
            begin
                seq[0] = cp[7:0];
            end
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        if (r >= 8 && r < 14 && len > 1)
        begin
            len--;
        end
        else if (r >= 14 && r < 20 && len > 1)
        begin
            seq[2'($urandom_range(len - 1, 1))] = 8'($urandom_range(255));
        end
        for (i = 0; i < len; i++)
        begin
            src_bytes.insert(src_bytes.size(), seq[i]);
        end
    endtask

    task automatic push_unit16(input logic [15:0] unit);
        src_bytes.insert(src_bytes.size(), unit[7:0]);
        src_bytes.insert(src_bytes.size(), unit[15:8]);
    endtask

    // pairs for supplementary planes, plus lone high and low surrogates
    task automatic add_utf16_symbol();
        logic [31:0] cp;
        int          r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            push_unit16(16'($urandom_range(16'hDBFF, 16'hD800)));
        end
        else if (r < 16)
        begin
            push_unit16(16'($urandom_range(16'hDFFF, 16'hDC00)));
        end
        else
        begin
            cp = pick_code_point(1'b0);
            if (cp >= 32'h10000 && cp <= 32'h10FFFF)
            begin
                cp = cp - 32'h10000;
                push_unit16({6'b110110, cp[19:10]});
                push_unit16({6'b110111, cp[9:0]});
            end
            else
            begin
                push_unit16(cp[15:0]);
            end
        end
    endtask

    task automatic add_symbol(input enc_t e);
        logic [31:0] cp;
        case (e)
            ENC_UTF8:  add_utf8_symbol();
            ENC_UTF16: add_utf16_symbol();
            ENC_UTF32:
            begin
                cp = pick_code_point(1'b1);
                src_bytes.insert(src_bytes.size(), cp[7:0]);
                src_bytes.insert(src_bytes.size(), cp[15:8]);
                src_bytes.insert(src_bytes.size(), cp[23:16]);
                src_bytes.insert(src_bytes.size(), cp[31:24]);
            end
            ENC_NONE:  src_bytes.insert(src_bytes.size(), 8'($urandom_range(255)));
        endcase
    endtask

    // Buffers of a few well-formed-ish symbols; a stray byte now and then
    // desyncs the unit boundary. End of data on most buffers, so state
    // sometimes carries into the next buffer.
    task automatic random_phase(input enc_t e, input int n_words);
        int sent;
        sent = 0;
        while (sent < n_words)
        begin
            src_bytes.delete();
            repeat ($urandom_range(5, 1)) add_symbol(e);
            if ($urandom_range(99) < 15)
            begin
                src_bytes.insert(src_bytes.size(), 8'($urandom_range(255)));
            end
            sent += src_bytes.size();
            send_buffer($urandom_range(99) < 60);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // UTF-8 straight out of reset. Directed: NUL, invalid lead FF,
        // overlong C0 80, encoded surrogate, F4 lead above U+10FFFF,
        // bad continuation then replay of the bytes behind the lead,
        // and a sequence truncated by end of data.
        src_bytes = '{8'h00, 8'hFF, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80,
                      8'hF4, 8'h90, 8'h80, 8'h80, 8'hE2, 8'h41, 8'h42};
        send_buffer(1'b0);
        src_bytes = '{8'hE2, 8'h82};
        send_buffer(1'b1);
        random_phase(ENC_UTF8, 55);
        quiesce();

        // UTF-16LE. Directed: high surrogate followed by a plain unit,
        // a proper pair, then a half unit dropped at end of data.
        set_encoding(ENC_UTF16);
        src_bytes = '{8'h00, 8'hD8, 8'h41, 8'h00, 8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h7A};
        send_buffer(1'b1);
        random_phase(ENC_UTF16, 45);
        quiesce();

        // UTF-32LE with no idling on either side
        calm <= 1'b1;
        set_encoding(ENC_UTF32);
        random_phase(ENC_UTF32, 55);
        quiesce();
        calm <= 1'b0;

        // unused selector: everything dropped
        set_encoding(ENC_NONE);
        random_phase(ENC_NONE, 12);
        quiesce();

        // back to UTF-8 after the unused selector
        set_encoding(ENC_UTF8);
        random_phase(ENC_UTF8, 20);
        quiesce();

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
